>>> rtl/stbs_pkg.sv
package stbs_pkg;

  localparam int IDX_W           = 8;
  localparam int RANGE_W         = IDX_W + 1;
  localparam int IN_VAL_W        = 32;
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } result_t;

endpackage

>>> rtl/stbs_ram.sv
module stbs_ram #(
  parameter int DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
  parameter int WIDTH = stbs_pkg::DEF_VALUE_WIDTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/stbs_search.sv
module stbs_search #(
  parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH,
  localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic                                 req_type,
  input  logic [stbs_pkg::IDX_W-1:0]           entry_index,
  input  logic signed [stbs_pkg::IN_VAL_W-1:0] entry_value,
  input  logic signed [stbs_pkg::IN_VAL_W-1:0] target,
  input  logic [stbs_pkg::IDX_W-1:0]           lo_bound,
  input  logic [stbs_pkg::IDX_W-1:0]           hi_bound,
  output logic                                 res_valid,
  input  logic                                 res_take,
  output stbs_pkg::result_t                    res,
  output logic                                 wr_en,
  output logic [AW-1:0]                        wr_addr,
  output logic [VALUE_WIDTH-1:0]               wr_data,
  output logic                                 rd_en,
  output logic [AW-1:0]                        rd_addr,
  input  logic [VALUE_WIDTH-1:0]               rd_data
);

  localparam int RW = stbs_pkg::RANGE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_EMIT
  } state_t;

  function automatic logic signed [VALUE_WIDTH-1:0] fit(
    input logic signed [stbs_pkg::IN_VAL_W-1:0] v
  );
    logic signed [63:0] ext;
    ext = 64'(v);
    return VALUE_WIDTH'(ext);
  endfunction

  function automatic logic [RW-1:0] mid_of(input logic [RW-1:0] lo, input logic [RW-1:0] hix);
    logic [RW-1:0] span;
    span = hix - lo - RW'(1);
    return lo + (span >> 1);
  endfunction

  state_t                         state_r, state_nxt;
  logic [RW-1:0]                  lo_r, lo_nxt;
  logic [RW-1:0]                  hix_r, hix_nxt;
  logic [RW-1:0]                  mid_r, mid_nxt;
  logic signed [VALUE_WIDTH-1:0]  key_r, key_nxt;
  stbs_pkg::result_t              res_r, res_nxt;

  logic                           accept;
  logic [RW-1:0]                  lo_in;
  logic [RW-1:0]                  hix_in;
  logic signed [VALUE_WIDTH-1:0]  probe;
  logic [RW-1:0]                  lo_step;
  logic [RW-1:0]                  hix_step;

  assign req_stall = (state_r != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign res_valid = (state_r == S_EMIT);
  assign res       = res_r;

  assign wr_en   = accept && (req_type == stbs_pkg::REQ_LOAD)
                   && (int'(entry_index) < TABLE_DEPTH);
  assign wr_addr = AW'(entry_index);
  assign wr_data = fit(entry_value);

  assign lo_in  = {1'b0, lo_bound};
  assign hix_in = (int'(hi_bound) > TABLE_DEPTH - 1) ? RW'(TABLE_DEPTH)
                                                    : ({1'b0, hi_bound} + RW'(1));
  assign probe  = $signed(rd_data);

  always_comb begin
    lo_step  = lo_r;
    hix_step = hix_r;
    if (probe < key_r) begin
      lo_step = mid_r + RW'(1);
    end else begin
      hix_step = mid_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hix_nxt   = hix_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = AW'(mid_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept && (req_type == stbs_pkg::REQ_SEARCH)) begin
          key_nxt       = fit(target);
          lo_nxt        = lo_in;
          hix_nxt       = hix_in;
          res_nxt.found = 1'b0;
          res_nxt.index = '0;
          if (lo_in < hix_in) begin
            mid_nxt   = mid_of(lo_in, hix_in);
            rd_en     = 1'b1;
            rd_addr   = AW'(mid_nxt);
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_PROBE: begin
        if (probe == key_r) begin
          res_nxt.found = 1'b1;
          res_nxt.index = mid_r[stbs_pkg::IDX_W-1:0];
          state_nxt     = S_EMIT;
        end else begin
          lo_nxt  = lo_step;
          hix_nxt = hix_step;
          if (lo_step < hix_step) begin
            mid_nxt = mid_of(lo_step, hix_step);
            rd_en   = 1'b1;
            rd_addr = AW'(mid_nxt);
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lo_r  <= lo_nxt;
    hix_r <= hix_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> rtl/sorted_table_binary_search_unit.sv
// Binary search over a table of signed words kept in ascending order.
// Input channel (in_valid/in_stall): a load transaction (in_req_type 0)
// writes in_entry_value to in_entry_index and gives no result; an index
// beyond the table is dropped. A search transaction (in_req_type 1) looks
// for in_target between in_lo_bound and in_hi_bound, both inclusive;
// in_hi_bound is clamped to the last entry.
// Result channel (out_valid/out_stall): one transaction per search with
// out_found and out_found_index (0 when not found).
// Timing: a load is written to the table when accepted. A search holds
// the input channel stalled through its k probes and until its result
// is taken (k is 0 for an empty range, at most 9 for a 256-entry table):
// one probe per cycle, set by the single read port of the table memory
// with its registered read. The result reaches out_* through an output
// register, which holds it, so the next transaction is taken while it
// waits; a stalled receiver holds the search in its final step once a
// second result is ready.
// Reset clears control state only; table entries are undefined until
// loaded and must not be probed before that.
module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic [stbs_pkg::IDX_W-1:0]           in_entry_index,
  input  logic signed [stbs_pkg::IN_VAL_W-1:0] in_entry_value,
  input  logic signed [stbs_pkg::IN_VAL_W-1:0] in_target,
  input  logic [stbs_pkg::IDX_W-1:0]           in_lo_bound,
  input  logic [stbs_pkg::IDX_W-1:0]           in_hi_bound,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_found,
  output logic [stbs_pkg::IDX_W-1:0]           out_found_index
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [VALUE_WIDTH-1:0]    wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [VALUE_WIDTH-1:0]    rd_data;
  logic                      res_valid;
  logic                      res_take;
  stbs_pkg::result_t         res;

  logic                      out_valid_r;
  stbs_pkg::result_t         out_res_r;

  stbs_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stbs_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req_stall   (in_stall),
    .req_type    (in_req_type),
    .entry_index (in_entry_index),
    .entry_value (in_entry_value),
    .target      (in_target),
    .lo_bound    (in_lo_bound),
    .hi_bound    (in_hi_bound),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_res_r.found;
  assign out_found_index = out_res_r.index;

endmodule
